FILE: rtl/core/itcf_pkg.sv
// ----------------------------------------------------------------------------
// itcf_pkg: shared types and constants of the tilt complementary filter
// Fixed-point formats, register codes, the arctangent table and the
// sequencer states used by the lanes and the top level.
// ----------------------------------------------------------------------------
package itcf_pkg;

  localparam int unsigned CORDIC_STEPS    = 16;
  localparam int unsigned ANGLE_FRAC_BITS = 8;

  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned CSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int unsigned IDX_W  = $clog2(ATAN_ENTRIES);

  localparam int unsigned ANG_W  = 24;                 // output angle width
  localparam int unsigned VEC_W  = 17;                 // atan2 operand (counts)
  localparam int unsigned XY_W   = 34;                 // CORDIC x/y datapath
  localparam int unsigned Z_W    = 21;                 // CORDIC angle, Q16 radians
  localparam int unsigned APR_W  = Z_W + 17;           // z times rad_to_deg
  localparam int unsigned ASHIFT = 24 - ANGLE_FRAC_BITS;

  localparam int unsigned MAG_W  = 16;
  localparam int unsigned US_W   = 20;
  localparam int unsigned PRD_W  = MAG_W + US_W;
  localparam int unsigned D_W    = 16 + 20;            // counts_per_dps * 10^6
  localparam int unsigned NUM_W  = PRD_W + ANGLE_FRAC_BITS + 1;
  localparam int unsigned REM_W  = D_W + 1;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned Q_W    = 26;                 // quotient magnitude kept
  localparam int unsigned INC_W  = Q_W + 1;
  localparam int unsigned SUM_W  = INC_W + 1;
  localparam int unsigned P1_W   = SUM_W + 17;
  localparam int unsigned P2_W   = ANG_W + 18;
  localparam int unsigned BL_W   = P1_W + 2;

  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic signed [Z_W-1:0] PI_Q16 = Z_W'(205887);

  localparam logic [15:0] BLEND_RST = 16'd64881;
  localparam logic [15:0] CPD_RST   = 16'd131;
  localparam logic [15:0] R2D_RST   = 16'd14668;

  typedef enum logic [1:0] {
    REG_BLEND_WEIGHT = 2'd0,
    REG_GYRO_CPD     = 2'd1,
    REG_RAD_TO_DEG   = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_ANGLE,
    ST_ACC,
    ST_MUL,
    ST_SUM
  } itcf_state_e;

  typedef struct packed {
    logic [15:0] blend_weight;
    logic [15:0] gyro_cpd;
    logic [15:0] rad_to_deg;
  } itcf_cfg_t;

  typedef struct packed {
    logic             load;
    logic             init;
    logic             step;
    logic             cstep;
    logic [IDX_W-1:0] idx;
    logic             angle;
    logic             acc;
    logic             mul;
    logic             fin;
    logic             seed;
  } itcf_ctrl_t;

  function automatic logic signed [Z_W-1:0] atan_q16(input logic [IDX_W-1:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:    r = Z_W'(51472);
      5'd1:    r = Z_W'(30386);
      5'd2:    r = Z_W'(16055);
      5'd3:    r = Z_W'(8150);
      5'd4:    r = Z_W'(4091);
      5'd5:    r = Z_W'(2047);
      5'd6:    r = Z_W'(1024);
      5'd7:    r = Z_W'(512);
      5'd8:    r = Z_W'(256);
      5'd9:    r = Z_W'(128);
      5'd10:   r = Z_W'(64);
      5'd11:   r = Z_W'(32);
      5'd12:   r = Z_W'(16);
      5'd13:   r = Z_W'(8);
      5'd14:   r = Z_W'(4);
      5'd15:   r = Z_W'(2);
      5'd16:   r = Z_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/itcf_if.sv
// ----------------------------------------------------------------------------
// itcf_if: sample and angle channels
// Valid/ready channels carrying one raw sample in and one angle pair out.
// ----------------------------------------------------------------------------
interface itcf_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] acc_x;
  logic [15:0] acc_y;
  logic [15:0] acc_z;
  logic [15:0] gyro_x;
  logic [15:0] gyro_y;
  logic [19:0] elapsed_us;

  modport source (output valid, mode, acc_x, acc_y, acc_z, gyro_x, gyro_y, elapsed_us,
                  input ready);
  modport sink   (input valid, mode, acc_x, acc_y, acc_z, gyro_x, gyro_y, elapsed_us,
                  output ready);
endinterface

interface itcf_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] roll_angle;
  logic [23:0] pitch_angle;

  modport source (output valid, roll_angle, pitch_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, output ready);
endinterface

FILE: rtl/core/itcf_lane.sv
// ----------------------------------------------------------------------------
// itcf_lane: one tilt axis
// Iterative vectoring CORDIC for the accelerometer angle, restoring divider
// for the gyro increment, and the blend into the axis angle register.
// ----------------------------------------------------------------------------
module itcf_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  itcf_pkg::itcf_ctrl_t              ctrl_i,
  input  itcf_pkg::itcf_cfg_t               cfg_i,
  input  logic signed [itcf_pkg::VEC_W-1:0] vy_i,
  input  logic signed [itcf_pkg::VEC_W-1:0] vx_i,
  input  logic signed [15:0]                gyro_i,
  input  logic [itcf_pkg::US_W-1:0]         us_i,
  output logic signed [itcf_pkg::ANG_W-1:0] angle_o
);

  localparam int unsigned XY_W  = itcf_pkg::XY_W;
  localparam int unsigned Z_W   = itcf_pkg::Z_W;
  localparam int unsigned ANG_W = itcf_pkg::ANG_W;

  // CORDIC registers
  logic signed [XY_W-1:0] x_q, y_q;
  logic signed [Z_W-1:0]  z_q;
  logic                   zero_q;
  // divider registers
  logic [itcf_pkg::PRD_W-1:0] prod_q;
  logic [itcf_pkg::D_W-1:0]   dval_q;
  logic [itcf_pkg::NUM_W-1:0] num_q;
  logic [itcf_pkg::REM_W-1:0] rem_q;
  logic                       gneg_q;
  // post stages
  logic signed [itcf_pkg::APR_W-1:0] aprod_q;
  logic signed [ANG_W-1:0]           acc_q;
  logic signed [itcf_pkg::SUM_W-1:0] sum_q;
  logic signed [itcf_pkg::P1_W-1:0]  p1_q;
  logic signed [itcf_pkg::P2_W-1:0]  p2_q;
  logic signed [ANG_W-1:0]           st_q, st_d;

  logic signed [XY_W-1:0] x0, y0, xs, ys;
  logic [15:0]            cpd_eff, mag;
  logic [itcf_pkg::REM_W-1:0] trial;
  logic signed [itcf_pkg::APR_W-1:0] around;
  logic signed [itcf_pkg::INC_W-1:0] inc;
  logic signed [itcf_pkg::BL_W-1:0]  bl;
  logic signed [itcf_pkg::BL_W-17:0] blsh;

  assign x0 = XY_W'(vx_i) <<< 14;
  assign y0 = XY_W'(vy_i) <<< 14;
  assign xs = x_q >>> ctrl_i.idx;
  assign ys = y_q >>> ctrl_i.idx;
  assign cpd_eff = (cfg_i.gyro_cpd == 16'd0) ? 16'd1 : cfg_i.gyro_cpd;
  assign mag = gyro_i[15] ? 16'(-gyro_i) : 16'(gyro_i);
  assign trial = {rem_q[itcf_pkg::REM_W-2:0], num_q[itcf_pkg::NUM_W-1]};

  assign around = aprod_q + (itcf_pkg::APR_W'(1) <<< (itcf_pkg::ASHIFT - 1));
  assign inc = gneg_q ? -itcf_pkg::INC_W'(num_q[itcf_pkg::Q_W-1:0])
                      :  itcf_pkg::INC_W'(num_q[itcf_pkg::Q_W-1:0]);
  assign bl = itcf_pkg::BL_W'(p1_q) + itcf_pkg::BL_W'(p2_q) + itcf_pkg::BL_W'(32768);
  assign blsh = bl[itcf_pkg::BL_W-1:16];

  always_comb begin
    if (ctrl_i.seed) begin
      st_d = acc_q;
    end else if (blsh > $signed((itcf_pkg::BL_W-16)'(2**(ANG_W-1) - 1))) begin
      st_d = {1'b0, {(ANG_W-1){1'b1}}};
    end else if (blsh < -$signed((itcf_pkg::BL_W-16)'(2**(ANG_W-1)))) begin
      st_d = {1'b1, {(ANG_W-1){1'b0}}};
    end else begin
      st_d = blsh[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      zero_q <= (vx_i == '0) && (vy_i == '0);
      if (vx_i < 0) begin
        x_q <= -x0;
        y_q <= -y0;
        z_q <= (vy_i >= 0) ? itcf_pkg::PI_Q16 : -itcf_pkg::PI_Q16;
      end else begin
        x_q <= x0;
        y_q <= y0;
        z_q <= '0;
      end
      gneg_q <= gyro_i[15];
      prod_q <= mag * us_i;
      dval_q <= cpd_eff * itcf_pkg::US_PER_S;
    end else if (ctrl_i.step && ctrl_i.cstep) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + itcf_pkg::atan_q16(ctrl_i.idx);
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - itcf_pkg::atan_q16(ctrl_i.idx);
      end
    end

    if (ctrl_i.init) begin
      num_q <= (itcf_pkg::NUM_W'(prod_q) << itcf_pkg::ANGLE_FRAC_BITS)
             + itcf_pkg::NUM_W'(dval_q >> 1);
      rem_q <= '0;
    end else if (ctrl_i.step) begin
      if (trial >= {1'b0, dval_q}) begin
        rem_q <= trial - {1'b0, dval_q};
        num_q <= {num_q[itcf_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        num_q <= {num_q[itcf_pkg::NUM_W-2:0], 1'b0};
      end
    end

    if (ctrl_i.angle) begin
      aprod_q <= (zero_q ? itcf_pkg::APR_W'(0) : itcf_pkg::APR_W'(z_q))
               * $signed({1'b0, cfg_i.rad_to_deg});
    end
    if (ctrl_i.acc) begin
      // result is at most 22 bits wide, so it never needs saturation
      acc_q <= ANG_W'(around >>> itcf_pkg::ASHIFT);
      sum_q <= itcf_pkg::SUM_W'(st_q) + itcf_pkg::SUM_W'(inc);
    end
    if (ctrl_i.mul) begin
      p1_q <= $signed({1'b0, cfg_i.blend_weight}) * sum_q;
      p2_q <= $signed(18'(32'd65536 - 32'(cfg_i.blend_weight))) * acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (ctrl_i.fin) begin
      st_q <= st_d;
    end
  end

  assign angle_o = st_d;

endmodule

FILE: rtl/core/imu_tilt_complementary_filter.sv
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter: roll/pitch complementary filter
// Two axis lanes, a shared sequencer and the result register.
// ----------------------------------------------------------------------------
// A sample is accepted only while the sequencer is idle, so one sample is fully
// processed before the next is taken. The accepting edge captures the sample
// and forms the products, the PREP state sets up the divider, the RUN state runs
// the bit-per-cycle gyro divider (the 16 CORDIC iterations run inside that span),
// then the ANGLE, ACC, MUL and SUM states scale, round, multiply and blend. The
// divider length dominates the time per sample. Roll and pitch run in two
// parallel lanes; the result register holds a finished pair while the next
// sample is taken in, and a stalled result beat holds the last stage.
module imu_tilt_complementary_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  itcf_in_if.sink     in_i,
  itcf_out_if.source  out_o
);

  itcf_pkg::itcf_state_e state_q, state_d;
  itcf_pkg::itcf_ctrl_t  ctrl;
  itcf_pkg::itcf_cfg_t   cfg_q;
  logic [itcf_pkg::CNT_W-1:0] cnt_q;
  logic                       seed_q;
  logic                       out_valid_q;
  logic [23:0]                roll_q, pitch_q;
  logic                       in_acc, out_free;
  logic signed [23:0]         roll_res, pitch_res;
  logic signed [itcf_pkg::VEC_W-1:0] vx, vy_roll, vy_pitch;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign vx       = itcf_pkg::VEC_W'($signed(in_i.acc_z));
  assign vy_roll  = itcf_pkg::VEC_W'($signed(in_i.acc_y));
  assign vy_pitch = -itcf_pkg::VEC_W'($signed(in_i.acc_x));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blend_weight <= itcf_pkg::BLEND_RST;
      cfg_q.gyro_cpd     <= itcf_pkg::CPD_RST;
      cfg_q.rad_to_deg   <= itcf_pkg::R2D_RST;
    end else if (cfg_we_i) begin
      case (itcf_pkg::reg_idx_e'(cfg_idx_i))
        itcf_pkg::REG_BLEND_WEIGHT: cfg_q.blend_weight <= cfg_data_i;
        itcf_pkg::REG_GYRO_CPD:     cfg_q.gyro_cpd     <= cfg_data_i;
        itcf_pkg::REG_RAD_TO_DEG:   cfg_q.rad_to_deg   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      itcf_pkg::ST_IDLE:  if (in_i.valid) state_d = itcf_pkg::ST_PREP;
      itcf_pkg::ST_PREP:  state_d = itcf_pkg::ST_RUN;
      itcf_pkg::ST_RUN: begin
        if (cnt_q == itcf_pkg::CNT_W'(itcf_pkg::DIV_STEPS - 1)) state_d = itcf_pkg::ST_ANGLE;
      end
      itcf_pkg::ST_ANGLE: state_d = itcf_pkg::ST_ACC;
      itcf_pkg::ST_ACC:   state_d = itcf_pkg::ST_MUL;
      itcf_pkg::ST_MUL:   state_d = itcf_pkg::ST_SUM;
      itcf_pkg::ST_SUM:   if (out_free) state_d = itcf_pkg::ST_IDLE;
      default:            state_d = itcf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    ctrl.seed  = seed_q;
    ctrl.idx   = cnt_q[itcf_pkg::IDX_W-1:0];
    ctrl.cstep = cnt_q < itcf_pkg::CNT_W'(itcf_pkg::CSTEPS);
    in_i.ready = 1'b0;
    case (state_q)
      itcf_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        ctrl.load  = in_i.valid;
      end
      itcf_pkg::ST_PREP:  ctrl.init  = 1'b1;
      itcf_pkg::ST_RUN:   ctrl.step  = 1'b1;
      itcf_pkg::ST_ANGLE: ctrl.angle = 1'b1;
      itcf_pkg::ST_ACC:   ctrl.acc   = 1'b1;
      itcf_pkg::ST_MUL:   ctrl.mul   = 1'b1;
      itcf_pkg::ST_SUM:   ctrl.fin   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itcf_pkg::ST_IDLE;
      cnt_q       <= '0;
      seed_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == itcf_pkg::ST_RUN) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (in_acc) begin
        seed_q <= in_i.mode;
      end
      if (ctrl.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge the lanes into one result beat
  always_ff @(posedge clk_i) begin
    if (ctrl.fin) begin
      roll_q  <= roll_res;
      pitch_q <= pitch_res;
    end
  end

  itcf_lane u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg_q),
    .vy_i    (vy_roll),
    .vx_i    (vx),
    .gyro_i  ($signed(in_i.gyro_x)),
    .us_i    (in_i.elapsed_us),
    .angle_o (roll_res)
  );

  itcf_lane u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg_q),
    .vy_i    (vy_pitch),
    .vx_i    (vx),
    .gyro_i  ($signed(in_i.gyro_y)),
    .us_i    (in_i.elapsed_us),
    .angle_o (pitch_res)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.roll_angle  = roll_q;
  assign out_o.pitch_angle = pitch_q;

endmodule

FILE: rtl/core/itcf_checker.sv
// ----------------------------------------------------------------------------
// itcf_checker: port-level checks of the tilt filter
// Watches the sample and angle channels of the top level.
// ----------------------------------------------------------------------------
module itcf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // one sample in flight: no second beat right after a taken one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after an accepted beat");

  // a result never appears the cycle after a sample is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("result too early after accept");

  // a new result is published as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result raised while input not ready");

  // hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result beat dropped while stalled");

endmodule

bind imu_tilt_complementary_filter itcf_checker u_itcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
